// ===== src/ssd_pkg.sv =====
package ssd_pkg;

    // Build-time defaults.
    localparam int NUM_DIGITS_DEF = 4;

    // Field and register widths.
    localparam int POS_W   = 2;
    localparam int CODE_W  = 4;
    localparam int SEG_W   = 8;
    localparam int DWELL_W = 16;
    localparam int FRAME_W = 16;
    localparam int BITS_W  = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Number of bits shifted for one digit.
    localparam logic [BITS_W-1:0] FRAME_BITS = 5'd16;

    // Register reset values.
    localparam logic               SCAN_ENABLE_RESET = 1'b1;
    localparam logic [DWELL_W-1:0] DWELL_RESET       = 16'd5000;

    // Register indexes, taken from the word address bit.
    localparam logic REG_SCAN_ENABLE = 1'b0;
    localparam logic REG_DWELL_TICKS = 1'b1;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Codes.
    localparam logic [CODE_W-1:0] CODE_BLANK = 4'd10;
    localparam logic [CODE_W-1:0] CODE_DASH  = 4'd11;
    localparam logic [CODE_W-1:0] CODE_LAST  = CODE_DASH;

    // Blank pattern, also the store reset value (active low segments).
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    // Scan sequencer phases.
    typedef enum logic [2:0] {
        PH_LATCH_LOW  = 3'd0,
        PH_DATA       = 3'd1,
        PH_CLK_HIGH   = 3'd2,
        PH_LATCH_HIGH = 3'd3,
        PH_DWELL      = 3'd4
    } t_phase;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic               scan_enable;
        logic [DWELL_W-1:0] dwell_ticks;
    } t_cfg;

    // Pin levels.
    typedef struct packed {
        logic sclk;
        logic rclk;
        logic dio;
    } t_pins;

    // Segment pattern for a valid code.
    function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] seg;
        case (code)
            4'd0:       seg = 8'hC0;
            4'd1:       seg = 8'hF9;
            4'd2:       seg = 8'hA4;
            4'd3:       seg = 8'hB0;
            4'd4:       seg = 8'h99;
            4'd5:       seg = 8'h92;
            4'd6:       seg = 8'h82;
            4'd7:       seg = 8'hF8;
            4'd8:       seg = 8'h80;
            4'd9:       seg = 8'h90;
            CODE_BLANK: seg = SEG_BLANK;
            CODE_DASH:  seg = 8'hBF;
            default:    seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ===== src/ssd_if.sv =====
// Input channel: one digit write or one scan tick per transaction.
interface ssd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [ssd_pkg::POS_W-1:0]     digit_position;
    logic [ssd_pkg::CODE_W-1:0]    digit_code;

    modport source (output valid, output kind, output digit_position, output digit_code,
                    input ready);
    modport sink   (input valid, input kind, input digit_position, input digit_code,
                    output ready);
endinterface

// Output channel: pin levels and write status per transaction.
interface ssd_out_if;
    logic valid;
    logic ready;
    logic serial_clock;
    logic latch_clock;
    logic serial_data;
    logic write_error;

    modport source (output valid, output serial_clock, output latch_clock,
                    output serial_data, output write_error, input ready);
    modport sink   (input valid, input serial_clock, input latch_clock,
                    input serial_data, input write_error, output ready);
endinterface

// ===== src/ssd_cfg.sv =====
module ssd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssd_pkg::PADDR_W-1:0]   paddr,
    input  logic [ssd_pkg::PDATA_W-1:0]   pwdata,
    output logic [ssd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output ssd_pkg::t_cfg                 o_cfg
);

    logic                          r_scan_enable;
    logic [ssd_pkg::DWELL_W-1:0]   r_dwell_ticks;
    logic                          reg_sel;
    logic                          wr_en;

    // Register index comes from the word address bit.
    assign reg_sel = paddr[ssd_pkg::PADDR_W-1];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_enable <= ssd_pkg::SCAN_ENABLE_RESET;
            r_dwell_ticks <= ssd_pkg::DWELL_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                ssd_pkg::REG_SCAN_ENABLE: r_scan_enable <= pwdata[0];
                ssd_pkg::REG_DWELL_TICKS: r_dwell_ticks <= pwdata[ssd_pkg::DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back.
    always_comb begin
        case (reg_sel)
            ssd_pkg::REG_SCAN_ENABLE:
                prdata = {{(ssd_pkg::PDATA_W-1){1'b0}}, r_scan_enable};
            ssd_pkg::REG_DWELL_TICKS:
                prdata = {{(ssd_pkg::PDATA_W-ssd_pkg::DWELL_W){1'b0}}, r_dwell_ticks};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg.scan_enable = r_scan_enable;
    assign o_cfg.dwell_ticks = r_dwell_ticks;

endmodule

// ===== src/ssd_store.sv =====
module ssd_store #(
    parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF,
    parameter int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [ssd_pkg::POS_W-1:0]     i_pos,
    input  logic [ssd_pkg::CODE_W-1:0]    i_code,
    input  logic [DIG_W-1:0]              i_rd_digit,
    output logic [ssd_pkg::SEG_W-1:0]     o_seg,
    output logic                          o_err
);

    logic [ssd_pkg::SEG_W-1:0] r_store [NUM_DIGITS];
    logic                      pos_ok;
    logic [DIG_W-1:0]          slot;

    // Codes above the dash are rejected.
    assign o_err  = (i_code > ssd_pkg::CODE_LAST);

    // Positions beyond the fitted digits are dropped; slots are mirrored.
    assign pos_ok = ({{(32-ssd_pkg::POS_W){1'b0}}, i_pos} < 32'(NUM_DIGITS));
    assign slot   = DIG_W'(NUM_DIGITS - 1 - int'(i_pos));

    // Digit store, reset to blanks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                r_store[d] <= ssd_pkg::SEG_BLANK;
            end
        end else if (i_wr_en && !o_err && pos_ok) begin
            r_store[slot] <= ssd_pkg::glyph(i_code);
        end
    end

    assign o_seg = r_store[i_rd_digit];

endmodule

// ===== src/ssd_scan.sv =====
module ssd_scan #(
    parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF,
    parameter int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  ssd_pkg::t_cfg                 i_cfg,
    input  logic [ssd_pkg::SEG_W-1:0]     i_seg,
    output logic [DIG_W-1:0]              o_rd_digit,
    output ssd_pkg::t_pins                o_pins_next
);

    ssd_pkg::t_phase                  r_phase, n_phase;
    logic [DIG_W-1:0]                 r_digit, n_digit;
    logic [ssd_pkg::BITS_W-1:0]       r_bits, n_bits;
    logic [ssd_pkg::FRAME_W-1:0]      r_frame, n_frame;
    logic [ssd_pkg::DWELL_W-1:0]      r_dwell, n_dwell;
    ssd_pkg::t_pins                   r_pins, n_pins;
    logic [DIG_W-1:0]                 digit_inc;
    logic [ssd_pkg::BITS_W-1:0]       bits_inc;
    logic                             step;

    assign step      = i_tick && i_cfg.scan_enable;
    assign bits_inc  = r_bits + 1'b1;
    assign digit_inc = (r_digit == DIG_W'(NUM_DIGITS - 1)) ? '0 : r_digit + 1'b1;

    // The store is read at the digit that the next frame will carry.
    assign o_rd_digit = (r_phase == ssd_pkg::PH_DWELL) ? digit_inc : r_digit;

    // Next state of the scan sequencer.
    always_comb begin
        n_phase = r_phase;
        n_digit = r_digit;
        n_bits  = r_bits;
        n_frame = r_frame;
        n_dwell = r_dwell;
        n_pins  = r_pins;
        if (step) begin
            case (r_phase)
                ssd_pkg::PH_DATA: begin
                    n_pins.sclk = 1'b0;
                    n_pins.dio  = r_frame[ssd_pkg::FRAME_W-1];
                    n_phase     = ssd_pkg::PH_CLK_HIGH;
                end
                ssd_pkg::PH_CLK_HIGH: begin
                    n_pins.sclk = 1'b1;
                    n_frame     = {r_frame[ssd_pkg::FRAME_W-2:0], 1'b0};
                    n_bits      = bits_inc;
                    n_phase     = (bits_inc >= ssd_pkg::FRAME_BITS) ?
                                  ssd_pkg::PH_LATCH_HIGH : ssd_pkg::PH_DATA;
                end
                ssd_pkg::PH_LATCH_HIGH: begin
                    n_pins.rclk = 1'b1;
                    n_dwell     = '0;
                    n_phase     = ssd_pkg::PH_DWELL;
                end
                ssd_pkg::PH_DWELL: begin
                    if (r_dwell < i_cfg.dwell_ticks) begin
                        n_dwell = r_dwell + 1'b1;
                    end else begin
                        n_digit     = digit_inc;
                        n_pins.rclk = 1'b0;
                        n_frame     = {i_seg, 8'd1 << digit_inc};
                        n_bits      = '0;
                        n_phase     = ssd_pkg::PH_DATA;
                    end
                end
                default: begin
                    // Latch-low phase and unused codes start the current digit.
                    n_pins.rclk = 1'b0;
                    n_frame     = {i_seg, 8'd1 << r_digit};
                    n_bits      = '0;
                    n_phase     = ssd_pkg::PH_DATA;
                end
            endcase
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ssd_pkg::PH_LATCH_LOW;
            r_digit <= '0;
            r_bits  <= '0;
            r_frame <= '0;
            r_dwell <= '0;
            r_pins  <= '0;
        end else begin
            r_phase <= n_phase;
            r_digit <= n_digit;
            r_bits  <= n_bits;
            r_frame <= n_frame;
            r_dwell <= n_dwell;
            r_pins  <= n_pins;
        end
    end

    assign o_pins_next = n_pins;

`ifndef NO_ASSERTIONS
    // The bit counter never passes the frame length.
    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= ssd_pkg::FRAME_BITS)
        else $error("bit counter past frame length");

    // Without an enabled tick, pins and phase hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> ($stable(r_pins) && $stable(r_phase)))
        else $error("scan state moved without an enabled tick");

    // The latch stays low while a frame is being shifted.
    a_latch_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ssd_pkg::PH_DATA || r_phase == ssd_pkg::PH_CLK_HIGH) |-> !r_pins.rclk)
        else $error("latch high during shifting");

    // Raising the latch leads into the dwell phase.
    a_latch_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_phase == ssd_pkg::PH_LATCH_HIGH) |=>
        (r_pins.rclk && r_phase == ssd_pkg::PH_DWELL))
        else $error("latch rise did not enter dwell");
`endif

endmodule

// ===== src/seven_segment_scan_driver_unit.sv =====
// Seven-segment scan driver for a multiplexed display behind two chained
// serial shift registers.
// Input channel i_in: each transaction is a digit write (kind 0, position and
// code) or a scan tick (kind 1). Every transaction yields exactly one
// transaction on o_out with the pin levels after it was handled and, for
// writes, a flag for a code above the dash.
// o_out.valid rises the cycle after acceptance; one transaction is accepted
// per cycle unless o_out stalls; sequencer and digit store update on accept.
// A digit frame takes 34 + dwell_ticks ticks: one tick that drops the latch and
// loads the frame, 16 bits of two ticks each, one tick that raises the latch,
// then dwell_ticks ticks of dwell.
// When the receiver stalls, the result register holds and i_in.ready drops
// until it is taken; ready stays high while the result moves on.
// Reset (synchronous, active low) blanks all digits, lowers all pins, puts the
// scan at the first digit and loads scan_enable = 1, dwell_ticks = 5000.
// The APB port holds scan_enable at address 0 and dwell_ticks at address 4.
module seven_segment_scan_driver_unit #(
    parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ssd_in_if.sink                        i_in,
    ssd_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssd_pkg::PADDR_W-1:0]   paddr,
    input  logic [ssd_pkg::PDATA_W-1:0]   pwdata,
    output logic [ssd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    ssd_pkg::t_cfg                 cfg;
    ssd_pkg::t_pins                pins_next;
    logic [DIG_W-1:0]              rd_digit;
    logic [ssd_pkg::SEG_W-1:0]     seg;
    logic                          code_err;
    logic                          accept;
    logic                          in_ready;
    logic                          r_out_valid;
    ssd_pkg::t_pins                r_out_pins;
    logic                          r_out_err;

    // Input is taken whenever the result register is free or being emptied.
    assign in_ready   = !r_out_valid || o_out.ready;
    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    ssd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssd_store #(
        .NUM_DIGITS (NUM_DIGITS),
        .DIG_W      (DIG_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (accept && (i_in.kind == ssd_pkg::KIND_WRITE)),
        .i_pos      (i_in.digit_position),
        .i_code     (i_in.digit_code),
        .i_rd_digit (rd_digit),
        .o_seg      (seg),
        .o_err      (code_err)
    );

    ssd_scan #(
        .NUM_DIGITS (NUM_DIGITS),
        .DIG_W      (DIG_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (accept && (i_in.kind == ssd_pkg::KIND_TICK)),
        .i_cfg       (cfg),
        .i_seg       (seg),
        .o_rd_digit  (rd_digit),
        .o_pins_next (pins_next)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_pins <= pins_next;
            r_out_err  <= (i_in.kind == ssd_pkg::KIND_WRITE) && code_err;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.serial_clock = r_out_pins.sclk;
    assign o_out.latch_clock  = r_out_pins.rclk;
    assign o_out.serial_data  = r_out_pins.dio;
    assign o_out.write_error  = r_out_err;

`ifndef NO_ASSERTIONS
    // Every accepted transaction shows up as a result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted transaction produced no result");
`endif

endmodule
